>>> hw/rtl/wsd_pkg.sv
package wsd_pkg;

  // Ring geometry
  localparam int DEPTH       = 16;
  localparam int PAYLOAD_W   = 32;
  localparam int IDX_W       = $clog2(DEPTH);
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int MAX_RESULTS = 16;

  // Fixed field widths of the channels
  localparam int MODE_W   = 3;
  localparam int WORD_W   = 32;
  localparam int SC_W     = 8;
  localparam int MAXC_W   = 5;
  localparam int STATUS_W = 2;
  localparam int QD_W     = 5;
  localparam int CTR_W    = 32;

  // Width used when comparing max_count against the fill level
  localparam int N_W = (CNT_W > MAXC_W) ? CNT_W : MAXC_W;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH       = 3'd0,
    MODE_POP        = 3'd1,
    MODE_PEEK       = 3'd2,
    MODE_STEAL_ONE  = 3'd3,
    MODE_STEAL_MANY = 3'd4,
    MODE_CLEAR      = 3'd5,
    MODE_CLR_STATS  = 3'd6,
    MODE_NOP        = 3'd7
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    FSM_IDLE,
    FSM_STEAL
  } fsm_t;

  typedef struct packed {
    logic [PAYLOAD_W-1:0] payload;
    logic [SC_W-1:0]      steals;
  } entry_t;

  // Command broadcast to every cell of the row
  typedef struct packed {
    logic             push;
    logic             shift;
    logic [CNT_W-1:0] count;
    entry_t           wdata;
  } cell_cmd_t;

  // Counter events for one result
  typedef struct packed {
    logic clr;
    logic push;
    logic pop;
    logic steal;
    logic attempt;
    logic fail;
  } stat_cmd_t;

  function automatic logic [SC_W-1:0] sat_inc(input logic [SC_W-1:0] v);
    logic [SC_W-1:0] r;
    r = (v == {SC_W{1'b1}}) ? v : v + 1'b1;
    return r;
  endfunction

endpackage

>>> hw/rtl/wsd_in_if.sv
interface wsd_in_if import wsd_pkg::*;;
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [WORD_W-1:0] task_payload;
  logic [SC_W-1:0]   task_steal_count;
  logic [MAXC_W-1:0] max_count;

  modport source (output valid, output mode, output task_payload,
                  output task_steal_count, output max_count, input ready);
  modport sink   (input valid, input mode, input task_payload,
                  input task_steal_count, input max_count, output ready);
endinterface

>>> hw/rtl/wsd_out_if.sv
interface wsd_out_if import wsd_pkg::*;;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic                task_valid;
  logic [WORD_W-1:0]   out_payload;
  logic [SC_W-1:0]     out_steal_count;
  logic                last;
  logic [QD_W-1:0]     queue_depth;
  logic [CTR_W-1:0]    pushed_total;
  logic [CTR_W-1:0]    popped_total;
  logic [CTR_W-1:0]    stolen_total;
  logic [CTR_W-1:0]    attempts_total;
  logic [CTR_W-1:0]    failed_total;

  modport source (output valid, output status, output task_valid, output out_payload,
                  output out_steal_count, output last, output queue_depth,
                  output pushed_total, output popped_total, output stolen_total,
                  output attempts_total, output failed_total, input ready);
  modport sink   (input valid, input status, input task_valid, input out_payload,
                  input out_steal_count, input last, input queue_depth,
                  input pushed_total, input popped_total, input stolen_total,
                  input attempts_total, input failed_total, output ready);
endinterface

>>> hw/rtl/wsd_cell.sv
module wsd_cell import wsd_pkg::*; (
  input  logic             clk,
  input  logic [CNT_W-1:0] idx,
  input  cell_cmd_t        cmd,
  input  entry_t           next_data,
  output entry_t           data
);

  entry_t data_r;
  entry_t data_nxt;

  // Take the pushed entry when this cell is the first free one,
  // otherwise advance the neighbour's entry towards the front.
  always_comb begin
    data_nxt = data_r;
    if (cmd.push && (cmd.count == idx)) begin
      data_nxt = cmd.wdata;
    end else if (cmd.shift) begin
      data_nxt = next_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

>>> hw/rtl/wsd_stats.sv
module wsd_stats import wsd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  stat_cmd_t        ev,
  output logic [CTR_W-1:0] pushed,
  output logic [CTR_W-1:0] popped,
  output logic [CTR_W-1:0] stolen,
  output logic [CTR_W-1:0] attempts,
  output logic [CTR_W-1:0] failed
);

  logic [CTR_W-1:0] pushed_r, popped_r, stolen_r, attempts_r, failed_r;

  always_ff @(posedge clk) begin
    if (!rst_n || ev.clr) begin
      pushed_r   <= '0;
      popped_r   <= '0;
      stolen_r   <= '0;
      attempts_r <= '0;
      failed_r   <= '0;
    end else begin
      if (ev.push)    pushed_r   <= pushed_r + 1'b1;
      if (ev.pop)     popped_r   <= popped_r + 1'b1;
      if (ev.steal)   stolen_r   <= stolen_r + 1'b1;
      if (ev.attempt) attempts_r <= attempts_r + 1'b1;
      if (ev.fail)    failed_r   <= failed_r + 1'b1;
    end
  end

  assign pushed   = pushed_r;
  assign popped   = popped_r;
  assign stolen   = stolen_r;
  assign attempts = attempts_r;
  assign failed   = failed_r;

endmodule

>>> hw/rtl/work_stealing_deque.sv
// Bounded work-stealing deque of 16 tasks (32-bit word plus 8-bit steal count)
// with five wrapping statistics counters. Push, pop, peek, steal-one, clear and
// counter reset each give one result; a new item is taken every cycle as long
// as the result register drains. Steal-many gives one result per cycle while it
// drains, min(max_count, depth, 16) of them (one empty result if that is 0), and
// holds off input until its last result is loaded. The queue is a row of cells
// with the front in cell 0: a pop shifts every cell one place towards the front,
// a push writes the first free cell and a steal reads the cell at the back. No
// clearing pass is needed after reset.
module work_stealing_deque import wsd_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  wsd_in_if.sink     in_chan,
  wsd_out_if.source  out_chan
);

  // Row of cells
  cell_cmd_t cmd;
  entry_t    cell_q [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t nb;
    if (i == DEPTH - 1) begin : g_tail
      assign nb = '0;
    end else begin : g_mid
      assign nb = cell_q[i+1];
    end
    wsd_cell u_cell (
      .clk       (clk),
      .idx       (CNT_W'(i)),
      .cmd       (cmd),
      .next_data (nb),
      .data      (cell_q[i])
    );
  end

  // Statistics
  stat_cmd_t        stat_ev;
  logic [CTR_W-1:0] pushed, popped, stolen, attempts, failed;

  wsd_stats u_stats (
    .clk      (clk),
    .rst_n    (rst_n),
    .ev       (stat_ev),
    .pushed   (pushed),
    .popped   (popped),
    .stolen   (stolen),
    .attempts (attempts),
    .failed   (failed)
  );

  // Control state
  fsm_t             state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] remain_r, remain_nxt;

  // Result register
  logic                 out_valid_r;
  logic [STATUS_W-1:0]  res_status_r, res_status_nxt;
  logic                 res_tv_r, res_tv_nxt;
  entry_t               res_entry_r, res_entry_nxt;
  logic                 res_last_r, res_last_nxt;
  logic                 load;

  logic       out_free;
  logic       in_ready;
  mode_t      mode;
  entry_t     back;
  entry_t     stolen_entry;
  logic [IDX_W-1:0] back_idx;
  logic [N_W-1:0]   maxc_ext, cnt_ext, lim, take_n;

  assign out_free = !out_valid_r || out_chan.ready;
  assign in_ready = (state_r == FSM_IDLE) && out_free;
  assign mode     = mode_t'(in_chan.mode);

  // Back of the queue; only meaningful while the queue holds something
  assign back_idx     = IDX_W'(count_r - 1'b1);
  assign back         = cell_q[back_idx];
  assign stolen_entry = '{payload: back.payload, steals: sat_inc(back.steals)};

  // Tasks that steal-many will take
  assign maxc_ext = N_W'(in_chan.max_count);
  assign cnt_ext  = N_W'(count_r);
  assign lim      = (maxc_ext < cnt_ext) ? maxc_ext : cnt_ext;
  assign take_n   = (lim < N_W'(MAX_RESULTS)) ? lim : N_W'(MAX_RESULTS);

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    remain_nxt     = remain_r;
    cmd.push       = 1'b0;
    cmd.shift      = 1'b0;
    cmd.count      = count_r;
    cmd.wdata      = '{payload: PAYLOAD_W'(in_chan.task_payload),
                       steals:  in_chan.task_steal_count};
    stat_ev        = '0;
    load           = 1'b0;
    res_status_nxt = ST_OK;
    res_tv_nxt     = 1'b0;
    res_entry_nxt  = '0;
    res_last_nxt   = 1'b1;

    case (state_r)
      FSM_IDLE: begin
        if (in_chan.valid && in_ready) begin
          load = 1'b1;
          case (mode)
            MODE_PUSH: begin
              if (count_r == CNT_W'(DEPTH)) begin
                res_status_nxt = ST_FULL;     // drop the task
              end else begin
                cmd.push     = 1'b1;
                count_nxt    = count_r + 1'b1;
                stat_ev.push = 1'b1;
              end
            end
            MODE_POP, MODE_PEEK: begin
              if (count_r == '0) begin
                res_status_nxt = ST_EMPTY;
              end else begin
                res_tv_nxt    = 1'b1;
                res_entry_nxt = cell_q[0];
                if (mode == MODE_POP) begin
                  cmd.shift   = 1'b1;
                  count_nxt   = count_r - 1'b1;
                  stat_ev.pop = 1'b1;
                end
              end
            end
            MODE_STEAL_ONE: begin
              stat_ev.attempt = 1'b1;
              if (count_r == '0) begin
                stat_ev.fail   = 1'b1;
                res_status_nxt = ST_EMPTY;
              end else begin
                stat_ev.steal = 1'b1;
                count_nxt     = count_r - 1'b1;
                res_tv_nxt    = 1'b1;
                res_entry_nxt = stolen_entry;
              end
            end
            MODE_STEAL_MANY: begin
              stat_ev.attempt = 1'b1;
              if (take_n == '0) begin
                stat_ev.fail   = 1'b1;
                res_status_nxt = ST_EMPTY;
              end else begin
                stat_ev.steal = 1'b1;
                count_nxt     = count_r - 1'b1;
                res_tv_nxt    = 1'b1;
                res_entry_nxt = stolen_entry;
                res_last_nxt  = (take_n == N_W'(1));
                remain_nxt    = CNT_W'(take_n - 1'b1);
                if (take_n != N_W'(1)) begin
                  state_nxt = FSM_STEAL;
                end
              end
            end
            MODE_CLEAR: begin
              count_nxt = '0;
            end
            MODE_CLR_STATS: begin
              stat_ev.clr = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      FSM_STEAL: begin
        // Hand out one more stolen task each time the result slot frees up
        if (out_free) begin
          load          = 1'b1;
          stat_ev.steal = 1'b1;
          count_nxt     = count_r - 1'b1;
          res_tv_nxt    = 1'b1;
          res_entry_nxt = stolen_entry;
          res_last_nxt  = (remain_r == CNT_W'(1));
          remain_nxt    = remain_r - 1'b1;
          if (remain_r == CNT_W'(1)) begin
            state_nxt = FSM_IDLE;
          end
        end
      end
      default: begin
        state_nxt = FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FSM_IDLE;
      count_r     <= '0;
      remain_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      remain_r <= remain_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload of the result register; hold while the transfer is stalled
  always_ff @(posedge clk) begin
    if (load) begin
      res_status_r <= res_status_nxt;
      res_tv_r     <= res_tv_nxt;
      res_entry_r  <= res_entry_nxt;
      res_last_r   <= res_last_nxt;
    end
  end

  assign in_chan.ready = in_ready;

  // Depth and counters only move when a result is loaded, so they always
  // match the result on show.
  assign out_chan.valid           = out_valid_r;
  assign out_chan.status          = res_status_r;
  assign out_chan.task_valid      = res_tv_r;
  assign out_chan.out_payload     = WORD_W'(res_entry_r.payload);
  assign out_chan.out_steal_count = res_entry_r.steals;
  assign out_chan.last            = res_last_r;
  assign out_chan.queue_depth     = QD_W'(count_r);
  assign out_chan.pushed_total    = pushed;
  assign out_chan.popped_total    = popped;
  assign out_chan.stolen_total    = stolen;
  assign out_chan.attempts_total  = attempts;
  assign out_chan.failed_total    = failed;

endmodule
